/* hw/rtl/data_uri_payload_decoder_defines.svh */
// Assertion macros shared by the data URI payload decoder RTL.
`ifndef DATA_URI_PAYLOAD_DECODER_DEFINES_SVH
`define DATA_URI_PAYLOAD_DECODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DURI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DURI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/duri_pkg.sv */
// Package with types, codes and lookup functions of the data URI payload decoder.
package duri_pkg;

  // Defaults of the top-level parameters.
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE64_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DECODED = 4'd1;
  localparam logic [31:0] MAX_DECODED_RESET = 32'hFFFF_FFFF;

  // Error codes reported on the end-of-payload result.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_SYMBOL  = 3'd1;
  localparam logic [2:0] ERR_BAD_PADDING = 3'd2;
  localparam logic [2:0] ERR_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd4;
  localparam logic [2:0] ERR_OVER_LIMIT  = 3'd5;

  // Special characters.
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // One accepted character after classification: the bytes it releases and,
  // on the last character, the final error code.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] nbytes;
    logic       last_char;
    logic [2:0] err;
  } desc_t;

  // A descriptor with its valid flag, as it travels between the parts.
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_chan_t;

  // Base64 alphabet lookup: bit 6 flags a valid symbol, bits 5:0 its value.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'h00;
    ok = 1'b1;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd26;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else begin
      ok = 1'b0;
    end
    return {ok, d[5:0]};
  endfunction

  // Hex digit lookup: bit 4 flags a valid digit, bits 3:0 its value.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'h00;
    ok = 1'b1;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
    end else begin
      ok = 1'b0;
    end
    return {ok, d[3:0]};
  endfunction

endpackage

/* hw/rtl/data_uri_payload_decoder.sv */
// Top level of the data URI payload decoder: configuration, front end, queue and back end.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  chars     | in        | push_i / full_o         | char_in_i, is_final_i
//  results   | out       | empty_o / pop_i         | data_byte_o, data_valid_o,
//            |           |                         | error_code_o, end_of_payload_o
//  config    | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One character is accepted per cycle unless full_o is high; the front end decodes it
// combinationally. Each character yields zero to three results, drained one per cycle by
// the back end as pop_i allows; results pass through the queue and the output register.
// Input stalls only when the descriptor queue is full; result stalls fill that queue.
// Reset clears the stream state and sets the registers to their reset values;
// there is no clearing pass, and cfg_ready_o is always high.
module data_uri_payload_decoder
  import duri_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [7:0]             char_in_i,
  input  logic                   is_final_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [7:0]             data_byte_o,
  output logic                   data_valid_o,
  output logic [2:0]             error_code_o,
  output logic                   end_of_payload_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

`include "data_uri_payload_decoder_defines.svh"

  logic        base64_q;
  logic [31:0] max_decoded_q;
  logic        accept;
  desc_chan_t  enq;
  desc_chan_t  head;
  logic        deq;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base64_q      <= 1'b0;
      max_decoded_q <= MAX_DECODED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_BASE64_MODE) begin
        base64_q <= cfg_data_i[0];
      end else if (cfg_index_i == CFG_MAX_DECODED) begin
        max_decoded_q <= cfg_data_i;
      end
    end
  end

  assign accept = push_i && !full_o;

  duri_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_in_i     (char_in_i),
    .is_final_i    (is_final_i),
    .base64_mode_i (base64_q),
    .max_decoded_i (max_decoded_q),
    .enq_o         (enq)
  );

  duri_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .deq_i  (deq),
    .head_o (head),
    .full_o (full_o)
  );

  duri_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .deq_o            (deq),
    .pop_i            (pop_i),
    .empty_o          (empty_o),
    .data_byte_o      (data_byte_o),
    .data_valid_o     (data_valid_o),
    .error_code_o     (error_code_o),
    .end_of_payload_o (end_of_payload_o)
  );

  // A result without a byte only closes a payload and carries a zero byte.
  `DURI_ASSERT_NOW(a_dataless_is_end, !empty_o && !data_valid_o, end_of_payload_o && data_byte_o == 8'h00, "data-less result is not an end of payload")
  // Error codes appear only on the closing result.
  `DURI_ASSERT_NOW(a_err_only_at_end, !empty_o && !end_of_payload_o, error_code_o == ERR_NONE, "error code on a non-final result")
  // The result register never reports an unknown error code.
  `DURI_ASSERT_NOW(a_err_in_range, !empty_o, error_code_o <= ERR_OVER_LIMIT, "error code out of range")
  // With the queue full the back end must have a result waiting next cycle.
  `DURI_ASSERT_NEXT(a_full_drains, full_o, !empty_o, "queue full but no result presented")

endmodule

/* hw/rtl/duri_front.sv */
// Front end: decodes each accepted character and works out which bytes it releases.
module duri_front
  import duri_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  char_in_i,
  input  logic        is_final_i,
  input  logic        base64_mode_i,
  input  logic [31:0] max_decoded_i,
  output desc_chan_t  enq_o
);

  localparam int LIM_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  logic [17:0]            acc_q, acc_d;
  logic [1:0]             pos_q, pos_d;
  logic [1:0]             pad_q, pad_d;
  logic [1:0]             esc_q, esc_d;
  logic [3:0]             hi_q, hi_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [2:0]             sticky_q, sticky_d;

  logic [6:0]  sx;
  logic [4:0]  nib;
  logic        is_eq;
  logic        is_pct;
  logic [1:0]  want;
  logic [7:0]  b0, b1, b2;
  logic [2:0]  step_err;
  logic [5:0]  sext;
  logic        grp_ok;
  logic [1:0]  pad_g;
  logic [23:0] word;

  logic [LIM_W-1:0] max_ext;
  logic [LIM_W-1:0] mask_ext;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] rem;
  logic [1:0]       room;
  logic [1:0]       nbytes;
  logic [2:0]       fin_err;
  logic [2:0]       sticky_end;

  assign sx     = sextet_of(char_in_i);
  assign nib    = nibble_of(char_in_i);
  assign is_eq  = (char_in_i == CH_EQUALS);
  assign is_pct = (char_in_i == CH_PERCENT);

  // Per-character state update in both modes.
  always_comb begin
    acc_d    = acc_q;
    pos_d    = pos_q;
    pad_d    = pad_q;
    esc_d    = esc_q;
    hi_d     = hi_q;
    want     = 2'd0;
    b0       = 8'h00;
    b1       = 8'h00;
    b2       = 8'h00;
    step_err = ERR_NONE;
    sext     = 6'd0;
    grp_ok   = 1'b0;
    pad_g    = pad_q;
    word     = {acc_q, 6'd0};
    if (sticky_q == ERR_NONE) begin
      if (base64_mode_i) begin
        if (pad_q != PAD_NONE && pos_q == 2'd0) begin
          // Nothing may follow a padded group.
          step_err = ERR_BAD_PADDING;
        end else if (!pos_q[1]) begin
          if (!sx[6]) begin
            step_err = ERR_BAD_SYMBOL;
          end else begin
            acc_d = {acc_q[11:0], sx[5:0]};
            pos_d = pos_q + 2'd1;
          end
        end else if (pos_q == 2'd2) begin
          if (is_eq) begin
            if (acc_q[3:0] != 4'd0) begin
              step_err = ERR_BAD_PADDING;
            end else begin
              pad_d = PAD_ONE;
              acc_d = {acc_q[11:0], 6'd0};
              pos_d = 2'd3;
            end
          end else if (!sx[6]) begin
            step_err = ERR_BAD_SYMBOL;
          end else begin
            acc_d = {acc_q[11:0], sx[5:0]};
            pos_d = 2'd3;
          end
        end else begin
          // Fourth symbol closes the group.
          if (pad_q == PAD_ONE) begin
            if (!is_eq) begin
              step_err = ERR_BAD_PADDING;
            end else begin
              pad_g  = PAD_TWO;
              grp_ok = 1'b1;
            end
          end else if (is_eq) begin
            if (acc_q[1:0] != 2'd0) begin
              step_err = ERR_BAD_PADDING;
            end else begin
              pad_g  = PAD_ONE;
              grp_ok = 1'b1;
            end
          end else if (!sx[6]) begin
            step_err = ERR_BAD_SYMBOL;
          end else begin
            sext   = sx[5:0];
            grp_ok = 1'b1;
          end
          if (grp_ok) begin
            word  = {acc_q, sext};
            pad_d = pad_g;
            acc_d = 18'd0;
            pos_d = 2'd0;
            b0    = word[23:16];
            b1    = word[15:8];
            b2    = word[7:0];
            if (pad_g == PAD_TWO) begin
              want = 2'd1;
            end else if (pad_g == PAD_ONE) begin
              want = 2'd2;
            end else begin
              want = 2'd3;
            end
          end
        end
      end else begin
        if (esc_q == ESC_IDLE) begin
          if (is_pct) begin
            esc_d = ESC_HIGH;
          end else begin
            want = 2'd1;
            b0   = char_in_i;
          end
        end else if (!nib[4]) begin
          step_err = ERR_BAD_ESCAPE;
        end else if (esc_q == ESC_HIGH) begin
          hi_d  = nib[3:0];
          esc_d = ESC_LOW;
        end else begin
          esc_d = ESC_IDLE;
          want  = 2'd1;
          b0    = {hi_q, nib[3:0]};
        end
      end
    end
  end

  // Byte limit: the smaller of the programmed limit and the counter range.
  // A limit lowered below the count already reached leaves no room at all.
  assign max_ext  = LIM_W'(max_decoded_i);
  assign mask_ext = LIM_W'({COUNT_WIDTH{1'b1}});
  assign lim      = (max_ext < mask_ext) ? max_ext : mask_ext;
  assign rem      = (lim > LIM_W'(count_q)) ? lim - LIM_W'(count_q) : '0;
  assign room     = (rem >= LIM_W'(3)) ? 2'd3 : rem[1:0];
  assign nbytes   = (want <= room) ? want : room;
  assign count_d  = count_q + COUNT_WIDTH'(nbytes);

  // Sticky error after the step, then the end-of-payload checks.
  always_comb begin
    if (sticky_q != ERR_NONE) begin
      sticky_d = sticky_q;
    end else if (step_err != ERR_NONE) begin
      sticky_d = step_err;
    end else if (nbytes != want) begin
      sticky_d = ERR_OVER_LIMIT;
    end else begin
      sticky_d = ERR_NONE;
    end
    fin_err = ERR_NONE;
    if (base64_mode_i) begin
      if (pos_d != 2'd0) begin
        fin_err = ERR_BAD_LENGTH;
      end
    end else if (esc_d != ESC_IDLE) begin
      fin_err = ERR_BAD_ESCAPE;
    end
    sticky_end = (sticky_d != ERR_NONE) ? sticky_d : fin_err;
  end

  // Stream state; everything clears after the final character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pos_q    <= '0;
      pad_q    <= PAD_NONE;
      esc_q    <= ESC_IDLE;
      hi_q     <= '0;
      count_q  <= '0;
      sticky_q <= ERR_NONE;
    end else if (accept_i) begin
      if (is_final_i) begin
        acc_q    <= '0;
        pos_q    <= '0;
        pad_q    <= PAD_NONE;
        esc_q    <= ESC_IDLE;
        hi_q     <= '0;
        count_q  <= '0;
        sticky_q <= ERR_NONE;
      end else begin
        acc_q    <= acc_d;
        pos_q    <= pos_d;
        pad_q    <= pad_d;
        esc_q    <= esc_d;
        hi_q     <= hi_d;
        count_q  <= count_d;
        sticky_q <= sticky_d;
      end
    end
  end

  // Only characters that give results are queued.
  assign enq_o.valid          = accept_i && (nbytes != 2'd0 || is_final_i);
  assign enq_o.desc.byte0     = b0;
  assign enq_o.desc.byte1     = b1;
  assign enq_o.desc.byte2     = b2;
  assign enq_o.desc.nbytes    = nbytes;
  assign enq_o.desc.last_char = is_final_i;
  assign enq_o.desc.err       = is_final_i ? sticky_end : ERR_NONE;

endmodule

/* hw/rtl/duri_queue.sv */
// Short descriptor queue between the front end and the result sequencer.
module duri_queue
  import duri_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_chan_t enq_i,
  input  logic       deq_i,
  output desc_chan_t head_o,
  output logic       full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  desc_t            slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_enq;
  logic             do_deq;

  assign do_enq = enq_i.valid && (count_q != CNT_W'(DEPTH));
  assign do_deq = deq_i && (count_q != '0);

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_enq && !do_deq) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_deq && !do_enq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      slots_q[wr_ptr_q] <= enq_i.desc;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.desc  = slots_q[rd_ptr_q];
  assign full_o       = (count_q == CNT_W'(DEPTH));

endmodule

/* hw/rtl/duri_back.sv */
// Back end: unpacks queued descriptors into single results in an output register.
module duri_back
  import duri_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_chan_t head_i,
  output logic       deq_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] data_byte_o,
  output logic       data_valid_o,
  output logic [2:0] error_code_o,
  output logic       end_of_payload_o
);

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       dv_q, dv_d;
  logic [2:0] err_q, err_d;
  logic       eop_q, eop_d;
  logic [1:0] idx_q, idx_d;

  logic       advance;
  logic       extra;
  logic [2:0] total;
  logic       last;
  logic       is_data;
  logic [7:0] sel_byte;

  // A data-less closing result follows when there is an error or no byte.
  assign extra   = head_i.desc.last_char &&
                   (head_i.desc.err != ERR_NONE || head_i.desc.nbytes == 2'd0);
  assign total   = {1'b0, head_i.desc.nbytes} + {2'b00, extra};
  assign last    = ({1'b0, idx_q} == total - 3'd1);
  assign is_data = (idx_q < head_i.desc.nbytes);
  assign advance = !out_valid_q || pop_i;
  assign deq_o   = advance && head_i.valid && last;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.desc.byte0;
      2'd1:    sel_byte = head_i.desc.byte1;
      default: sel_byte = head_i.desc.byte2;
    endcase
  end

  // Result for the current position within the head descriptor.
  always_comb begin
    if (is_data) begin
      byte_d = sel_byte;
      dv_d   = 1'b1;
      err_d  = ERR_NONE;
      eop_d  = head_i.desc.last_char && !extra &&
               ({1'b0, idx_q} == {1'b0, head_i.desc.nbytes} - 3'd1);
    end else begin
      byte_d = 8'h00;
      dv_d   = 1'b0;
      err_d  = head_i.desc.err;
      eop_d  = 1'b1;
    end
    idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= head_i.valid;
      if (head_i.valid) begin
        idx_q <= idx_d;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance && head_i.valid) begin
      byte_q <= byte_d;
      dv_q   <= dv_d;
      err_q  <= err_d;
      eop_q  <= eop_d;
    end
  end

  assign empty_o          = !out_valid_q;
  assign data_byte_o      = byte_q;
  assign data_valid_o     = dv_q;
  assign error_code_o     = err_q;
  assign end_of_payload_o = eop_q;

endmodule
